FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held
`define LFR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Concurrent assertion that is checked at every rising clock edge
`define LFR_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: rtl/lfr_pkg.sv
// ---------------------------------------------------------------------------
// LRU frame replacer package
// Field widths, operation codes, sequencer states and the order RAM request.
// ---------------------------------------------------------------------------
package lfr_pkg;

    localparam int FRAME_W = 6;             // frame number width
    localparam int COUNT_W = 7;             // evictable count field width
    localparam int FRAME_LIMIT = 1 << FRAME_W;

    // request operation codes; the spare code is a no-op
    typedef enum logic [1:0] {
        FUNC_VICTIM = 2'd0,
        FUNC_PIN    = 2'd1,
        FUNC_UNPIN  = 2'd2
    } t_func;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_DONE
    } t_state;

    // one write port and one read port into the order RAM
    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] waddr;
        logic [FRAME_W-1:0] wdata;
        logic               re;
        logic [FRAME_W-1:0] raddr;
    } t_ram_req;

endpackage

FILE: rtl/lru_frame_replacer_unit.sv
// ---------------------------------------------------------------------------
// LRU frame replacer
// Keeps evictable frames in recency order; serves victim, pin and unpin.
// ---------------------------------------------------------------------------
// Sequence: a request passes ST_START; unpin, no-op, empty victim and pin of an
//   untracked frame go on to ST_DONE, other victim and pin walk the order first.
// Throughput: one request at a time; a victim or pin walks the order RAM one
//   entry a cycle through its single read port, compacting behind the read.
// Reset: tracked flags, count and handshake state clear at once; the order
//   RAM is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module lru_frame_replacer_unit #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_func,
    input  logic [lfr_pkg::FRAME_W-1:0]   i_frame,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [lfr_pkg::FRAME_W-1:0]   o_victim_frame,
    output logic [lfr_pkg::COUNT_W-1:0]   o_evictable_count
);
    import lfr_pkg::*;

    // only frame numbers the field can carry are ever tracked
    localparam int SLOTS = (NUM_FRAMES < FRAME_LIMIT) ? NUM_FRAMES : FRAME_LIMIT;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam logic [FRAME_W:0] SLOTS_F = (FRAME_W + 1)'(SLOTS);
    localparam logic [CW-1:0]    SLOTS_C = CW'(SLOTS);

    t_state              r_state, n_state;
    logic [1:0]          r_func, n_func;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [SLOTS-1:0]    r_flag, n_flag;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    logic                r_shift, n_shift;
    logic                r_is_victim, n_is_victim;
    logic                r_found, n_found;
    logic [FRAME_W-1:0]  r_vf, n_vf;
    logic                r_o_valid, n_o_valid;
    logic                r_o_found, n_o_found;
    logic [FRAME_W-1:0]  r_o_vf, n_o_vf;
    logic [COUNT_W-1:0]  r_o_count, n_o_count;

    t_ram_req            w_ram_req;
    logic [FRAME_W-1:0]  w_ram_q;
    logic                w_frame_ok;
    logic                w_hit;
    logic                w_unpin_ok;
    logic                w_walk_start;
    logic                w_issue;
    logic                w_walk_end;
    logic                w_out_free;
    logic [FRAME_W-1:0]  w_clr_frame;

    // order store
    lfr_order_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_q)
    );

    // request decode
    assign w_frame_ok   = {1'b0, r_frame} < SLOTS_F;
    assign w_hit        = w_frame_ok && r_flag[r_frame[AW-1:0]];
    assign w_unpin_ok   = (r_func == FUNC_UNPIN) && w_frame_ok && !w_hit
                          && (r_count < SLOTS_C);
    assign w_walk_start = ((r_func == FUNC_VICTIM) && (r_count != '0))
                          || ((r_func == FUNC_PIN) && w_hit);

    // walk control: reads run ahead, writes trail one entry behind
    assign w_issue     = r_ptr < r_count;
    assign w_walk_end  = !w_issue && !r_pend;
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_clr_frame = r_is_victim ? r_vf : r_frame;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_START;
            end
            ST_START: begin
                n_state = w_walk_start ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                if (w_walk_end) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and RAM accesses
    always_comb begin
        n_func      = r_func;
        n_frame     = r_frame;
        n_flag      = r_flag;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_shift     = r_shift;
        n_is_victim = r_is_victim;
        n_found     = r_found;
        n_vf        = r_vf;
        n_o_valid   = r_o_valid;
        n_o_found   = r_o_found;
        n_o_vf      = r_o_vf;
        n_o_count   = r_o_count;
        w_ram_req   = '0;

        // result taken downstream
        if (r_o_valid && !i_stall) n_o_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_func  = i_func;
                    n_frame = i_frame;
                end
            end
            ST_START: begin
                n_found     = 1'b0;
                n_vf        = '0;
                n_ptr       = '0;
                n_pend      = 1'b0;
                n_shift     = (r_func == FUNC_VICTIM);
                n_is_victim = (r_func == FUNC_VICTIM);
                // unpin appends at the most-recent end
                if (w_unpin_ok) begin
                    w_ram_req.we    = 1'b1;
                    w_ram_req.waddr = FRAME_W'(r_count[AW-1:0]);
                    w_ram_req.wdata = r_frame;
                    n_flag[r_frame[AW-1:0]] = 1'b1;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            ST_WALK: begin
                n_pend = w_issue;
                if (w_issue) begin
                    w_ram_req.re    = 1'b1;
                    w_ram_req.raddr = FRAME_W'(r_ptr[AW-1:0]);
                    n_ptr           = CW'(r_ptr + 1'b1);
                    n_pend_addr     = r_ptr[AW-1:0];
                end
                if (r_pend) begin
                    if (r_shift) begin
                        // close the gap: move each later entry down by one
                        if (r_pend_addr != '0) begin
                            w_ram_req.we    = 1'b1;
                            w_ram_req.waddr = FRAME_W'(AW'(r_pend_addr - 1'b1));
                            w_ram_req.wdata = w_ram_q;
                        end
                        if (r_is_victim && (r_pend_addr == '0)) begin
                            n_found = 1'b1;
                            n_vf    = w_ram_q;
                        end
                    end else if (w_ram_q == r_frame) begin
                        n_shift = 1'b1;
                    end
                end
                if (w_walk_end) begin
                    n_count = CW'(r_count - 1'b1);
                    n_flag[w_clr_frame[AW-1:0]] = 1'b0;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_found;
                    n_o_vf    = r_vf;
                    n_o_count = COUNT_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_flag    <= '0;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flag    <= n_flag;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_frame     <= n_frame;
        r_ptr       <= n_ptr;
        r_pend_addr <= n_pend_addr;
        r_shift     <= n_shift;
        r_is_victim <= n_is_victim;
        r_found     <= n_found;
        r_vf        <= n_vf;
        r_o_found   <= n_o_found;
        r_o_vf      <= n_o_vf;
        r_o_count   <= n_o_count;
    end

    // ports
    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = r_o_valid;
    assign o_found           = r_o_found;
    assign o_victim_frame    = r_o_vf;
    assign o_evictable_count = r_o_count;

    // checks
    `LFR_ASSERT_RST(a_count_matches_flags, i_clk, i_rst_n, $countones(r_flag) == int'(r_count), "tracked count differs from flag population")
    `LFR_ASSERT_RST(a_ram_no_collide, i_clk, i_rst_n, (w_ram_req.we && w_ram_req.re) |-> (w_ram_req.waddr != w_ram_req.raddr), "order RAM read and write hit one entry")
    `LFR_ASSERT_RST(a_pin_located, i_clk, i_rst_n, (r_state == ST_WALK && w_walk_end && !r_is_victim) |-> r_shift, "pinned frame not found in order")
    `LFR_ASSERT_RST(a_victim_taken, i_clk, i_rst_n, (r_state == ST_WALK && w_walk_end && r_is_victim) |-> r_found, "victim walk ended without a frame")

endmodule

FILE: rtl/lfr_order_ram.sv
// ---------------------------------------------------------------------------
// LRU order RAM
// Simple dual-port store of frame numbers with a registered read.
// ---------------------------------------------------------------------------
module lfr_order_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  lfr_pkg::t_ram_req             i_req,
    output logic [lfr_pkg::FRAME_W-1:0]   o_rdata
);
    import lfr_pkg::*;

    logic [FRAME_W-1:0] r_mem [DEPTH];
    logic [FRAME_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb_lru_frame_replacer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU frame replacer testbench
// Drives victim, pin and unpin requests through the valid/stall input channel
// with random gaps, back-pressures the result channel at random, and checks
// each result against a queued recency-order model or a fixed row's value. A
// short table of directed requests opens the run; phased random traffic (fill,
// drain, churn, noise) follows so the order runs full and empty many times.
// ---------------------------------------------------------------------------
module tb_lru_frame_replacer_unit;

    import lfr_pkg::*;

    localparam int NUM_FRAMES = 64;
    localparam int RAND_ITEMS = 800;
    localparam int DIR_ROWS   = 17;
    localparam int TAIL_CYCLES = 16;
    localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, a no-op

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] victim_frame;
        logic [COUNT_W-1:0] evictable_count;
    } t_lru_result;

    // fixed = 1: the expected result is given in the row itself
    typedef struct packed {
        logic [1:0]         func;
        logic [FRAME_W-1:0] frame;
        logic               fixed;
        t_lru_result        want;
    } t_dir_row;

    typedef enum int {
        GEN_FILL,
        GEN_DRAIN,
        GEN_CHURN,
        GEN_NOISE
    } t_gen_mode;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [1:0]         i_func  = '0;
    logic [FRAME_W-1:0] i_frame = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_found;
    logic [FRAME_W-1:0] o_victim_frame;
    logic [COUNT_W-1:0] o_evictable_count;

    // recency model: front is least recent
    logic [FRAME_W-1:0] recency_q[$];
    bit                 is_tracked [NUM_FRAMES];

    t_lru_result        pending_q[$];
    int                 fail_cnt = 0;
    bit                 quiet    = 1'b0;   // no idling on either side

    // Directed requests: empty-order cases, duplicate unpin, pins from head,
    // middle and tail, the spare code and both frame extremes
    t_dir_row dir_table [DIR_ROWS] = '{
        '{FUNC_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_PIN,    6'd5,  1'b1, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_SPARE,  6'd63, 1'b1, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_UNPIN,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd1}},
        '{FUNC_UNPIN,  6'd63, 1'b1, '{1'b0, 6'd0, 7'd2}},
        '{FUNC_UNPIN,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd2}},
        '{FUNC_UNPIN,  6'd21, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_UNPIN,  6'd42, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_PIN,    6'd63, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_PIN,    6'd42, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_UNPIN,  6'd63, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_SPARE,  6'd0,  1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_VICTIM, 6'd63, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_PIN,    6'd21, 1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_VICTIM, 6'd0,  1'b0, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_VICTIM, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0}},
        '{FUNC_PIN,    6'd0,  1'b1, '{1'b0, 6'd0, 7'd0}}
    };

    lru_frame_replacer_unit #(
        .NUM_FRAMES(NUM_FRAMES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_frame           (i_frame),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_found           (o_found),
        .o_victim_frame    (o_victim_frame),
        .o_evictable_count (o_evictable_count)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Apply one request to the recency model and return its result
    function automatic t_lru_result lru_apply(input logic [1:0] func,
                                              input logic [FRAME_W-1:0] frame);
        t_lru_result res;
        int          pos;
        res = '0;
        pos = -1;
        case (func)
            FUNC_VICTIM: begin
                if (recency_q.size() > 0) begin
                    res.found        = 1'b1;
                    res.victim_frame = recency_q.pop_front();
                    is_tracked[res.victim_frame] = 1'b0;
                end
            end
            FUNC_PIN: begin
                if (is_tracked[frame]) begin
                    foreach (recency_q[i]) begin
                        if (pos < 0 && recency_q[i] == frame) pos = i;
                    end
                    if (pos >= 0) recency_q.delete(pos);
                    is_tracked[frame] = 1'b0;
                end
            end
            FUNC_UNPIN: begin
                if (!is_tracked[frame] && recency_q.size() < NUM_FRAMES) begin
                    recency_q.push_back(frame);
                    is_tracked[frame] = 1'b1;
                end
            end
            default: ;
        endcase
        res.evictable_count = COUNT_W'(recency_q.size());
        return res;
    endfunction

    // Mostly a frame that is in the order, otherwise any frame
    function automatic logic [FRAME_W-1:0] pick_tracked();
        if (recency_q.size() > 0 && $urandom_range(0, 99) < 85)
            return recency_q[$urandom_range(0, recency_q.size() - 1)];
        return FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
    endfunction

    // Mostly a frame that is not in the order, otherwise any frame
    function automatic logic [FRAME_W-1:0] pick_untracked();
        logic [FRAME_W-1:0] spare_q[$];
        for (int f = 0; f < NUM_FRAMES; f++) begin
            if (!is_tracked[f]) spare_q.push_back(FRAME_W'(f));
        end
        if (spare_q.size() > 0 && $urandom_range(0, 99) < 85)
            return spare_q[$urandom_range(0, spare_q.size() - 1)];
        return FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
    endfunction

    // One input transfer after a random gap; valid stays high across
    // back-to-back requests
    task automatic send_request(input logic [1:0] func, input logic [FRAME_W-1:0] frame,
                                input logic fixed, input t_lru_result want);
        int          gap;
        t_lru_result res;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_frame <= frame;
        do @(posedge i_clk); while (o_stall);
        res = lru_apply(func, frame);
        pending_q.push_back(fixed ? want : res);
    endtask

    // Reset, stimulus and end of run
    initial begin : stimulus
        t_gen_mode   mode;
        int          left;
        int          roll;
        logic [1:0]  func;
        logic [FRAME_W-1:0] frame;
        mode = GEN_FILL;
        left = 90;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[r]) begin
            send_request(dir_table[r].func, dir_table[r].frame,
                         dir_table[r].fixed, dir_table[r].want);
        end

        // phased random traffic, first phase fills the order
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (left == 0) begin
                mode  = t_gen_mode'($urandom_range(0, 3));
                left  = $urandom_range(30, 120);
                quiet = ($urandom_range(0, 3) == 0);
            end
            left--;
            roll  = $urandom_range(0, 99);
            frame = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
            case (mode)
                GEN_FILL: begin
                    if (roll < 90) begin
                        func  = FUNC_UNPIN;
                        frame = pick_untracked();
                    end else if (roll < 95) begin
                        func  = FUNC_PIN;
                        frame = pick_tracked();
                    end else begin
                        func  = FUNC_VICTIM;
                    end
                end
                GEN_DRAIN: begin
                    if (roll < 60) begin
                        func  = FUNC_VICTIM;
                    end else if (roll < 85) begin
                        func  = FUNC_PIN;
                        frame = pick_tracked();
                    end else begin
                        func  = FUNC_UNPIN;
                    end
                end
                GEN_CHURN: begin
                    if (roll < 35) begin
                        func  = FUNC_PIN;
                        frame = pick_tracked();
                    end else if (roll < 70) begin
                        func  = FUNC_UNPIN;
                    end else if (roll < 90) begin
                        func  = FUNC_VICTIM;
                    end else begin
                        func  = FUNC_PIN;
                    end
                end
                default: begin
                    func = 2'($urandom_range(0, 3));
                end
            endcase
            send_request(func, frame, 1'b0, '0);
        end
        i_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result-side back-pressure: stall count drawn per transfer, counted
    // either from the moment valid shows or straight away
    initial begin : result_stall
        int n;
        bit early;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n     = quiet ? 0 : $urandom_range(0, 3);
            early = $urandom_range(0, 1);
            if (n > 0) begin
                i_stall <= 1'b1;
                while (n > 0) begin
                    @(posedge i_clk);
                    if (o_valid === 1'b1 || early) n--;
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && !i_stall));
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_lru_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    fail_cnt++;
                end
                if (o_victim_frame !== want.victim_frame) begin
                    $error("victim_frame: expected %0d, got %0d",
                           want.victim_frame, o_victim_frame);
                    fail_cnt++;
                end
                if (o_evictable_count !== want.evictable_count) begin
                    $error("evictable_count: expected %0d, got %0d",
                           want.evictable_count, o_evictable_count);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #(10_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lfr_pkg.sv
rtl/lfr_order_ram.sv
rtl/lru_frame_replacer_unit.sv
tb/tb_lru_frame_replacer_unit.sv
